// ----- src/tpe_pkg.sv -----
`default_nettype none

package tpe_pkg;

    // Table pool geometry.
    localparam int TABLE_FRAMES      = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int FRAME_W           = $clog2(TABLE_FRAMES);
    localparam int NFF_W             = $clog2(TABLE_FRAMES + 1);
    localparam int ADDR_W            = FRAME_W + IDX_W;
    localparam int DEPTH             = TABLE_FRAMES * ENTRIES_PER_TABLE;

    // Field widths.
    localparam int DESC_W    = 64;
    localparam int VA_W      = 39;
    localparam int PA_W      = 48;
    localparam int OFS_W     = 12;
    localparam int PAGE_W    = PA_W - OFS_W;
    localparam int HI_PAD_W  = DESC_W - PA_W;

    // Descriptor attribute bits in the low 12 bits.
    localparam logic [OFS_W-1:0] D_VALID    = 12'h001;
    localparam logic [OFS_W-1:0] D_TABLE    = 12'h002;
    localparam logic [OFS_W-1:0] D_ATTR     = 12'h004;
    localparam logic [OFS_W-1:0] D_SH_INNER = 12'h300;
    localparam logic [OFS_W-1:0] D_AF       = 12'h400;

    // Request codes.
    localparam logic [1:0] REQ_MAP       = 2'd0;
    localparam logic [1:0] REQ_UNMAP     = 2'd1;
    localparam logic [1:0] REQ_TRANSLATE = 2'd2;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_MAPPED  = 3'd1,
        ST_BLOCK_LEAF  = 3'd2,
        ST_EXHAUSTED   = 3'd3,
        ST_NOT_PRESENT = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [VA_W-1:0] virt_addr;
        logic [PA_W-1:0] phys_addr;
        logic [2:0]      access_flags;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [PA_W-1:0]   translated_addr;
        logic [DESC_W-1:0] leaf_descriptor;
    } res_t;

    // Low attribute bits of a page descriptor, AP taken from the user and writable flags.
    function automatic logic [OFS_W-1:0] page_attrs(input logic [2:0] flags);
        logic [1:0] ap;
        if (flags[2]) begin
            ap = flags[1] ? 2'b01 : 2'b11;
        end else begin
            ap = flags[1] ? 2'b00 : 2'b10;
        end
        return D_VALID | D_TABLE | D_AF | D_SH_INNER | D_ATTR | {4'b0000, ap, 6'b000000};
    endfunction

    // Table descriptor that links to the given frame.
    function automatic logic [DESC_W-1:0] table_desc(input logic [FRAME_W-1:0] frame);
        return {{HI_PAD_W{1'b0}}, PAGE_W'(frame), D_VALID | D_TABLE};
    endfunction

endpackage

`default_nettype wire

// ----- src/tpe_ram.sv -----
`default_nettype none

module tpe_ram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 64
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/tpe_walk.sv -----
`default_nettype none

module tpe_walk (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire tpe_pkg::req_t                   req,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output tpe_pkg::res_t                        res,
    output logic                                 ram_we,
    output logic [tpe_pkg::ADDR_W-1:0]           ram_waddr,
    output logic [tpe_pkg::DESC_W-1:0]           ram_wdata,
    output logic                                 ram_re,
    output logic [tpe_pkg::ADDR_W-1:0]           ram_raddr,
    input  wire logic [tpe_pkg::DESC_W-1:0]      ram_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_LEAF,
        S_DONE
    } state_t;

    state_t                           state_reg, state_next;
    logic [tpe_pkg::ADDR_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [tpe_pkg::NFF_W-1:0]        nff_reg, nff_next;
    logic [1:0]                       op_reg, op_next;
    logic [tpe_pkg::VA_W-1:0]         va_reg, va_next;
    logic [tpe_pkg::PAGE_W-1:0]       pa_reg, pa_next;
    logic [2:0]                       flags_reg, flags_next;
    logic [tpe_pkg::FRAME_W-1:0]      frame_reg, frame_next;
    tpe_pkg::res_t                    res_reg, res_next;

    logic [tpe_pkg::IDX_W-1:0] i1, i2, i3;
    logic                      d_valid, d_table, d_out_of_pool, pool_empty;
    logic [tpe_pkg::FRAME_W-1:0] d_frame, alloc_frame;

    assign i1 = va_reg[38:30];
    assign i2 = va_reg[29:21];
    assign i3 = va_reg[20:12];

    // Decode of the descriptor just read.
    assign d_valid       = ram_rdata[0];
    assign d_table       = ram_rdata[1];
    assign d_out_of_pool = ram_rdata[47:12] >= tpe_pkg::PAGE_W'(tpe_pkg::TABLE_FRAMES);
    assign d_frame       = ram_rdata[12 +: tpe_pkg::FRAME_W];
    assign pool_empty    = nff_reg >= tpe_pkg::NFF_W'(tpe_pkg::TABLE_FRAMES);
    assign alloc_frame   = nff_reg[tpe_pkg::FRAME_W-1:0];

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // Walk sequencer: one descriptor read per level, writes alongside.
    always_comb begin
        logic [tpe_pkg::FRAME_W-1:0] parent;
        logic [tpe_pkg::FRAME_W-1:0] child;
        logic [tpe_pkg::IDX_W-1:0]   cur_idx;
        logic                        descend;

        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        nff_next     = nff_reg;
        op_next      = op_reg;
        va_next      = va_reg;
        pa_next      = pa_reg;
        flags_next   = flags_reg;
        frame_next   = frame_reg;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        parent       = (state_reg == S_RD1) ? '0 : frame_reg;
        cur_idx      = (state_reg == S_RD1) ? i1 : i2;
        child        = d_frame;
        descend      = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + tpe_pkg::ADDR_W'(1);
                if (clr_cnt_reg == tpe_pkg::ADDR_W'(tpe_pkg::DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (req_valid) begin
                    op_next    = req.req_type;
                    va_next    = req.virt_addr;
                    pa_next    = req.phys_addr[47:12];
                    flags_next = req.access_flags;
                    if (req.req_type inside {tpe_pkg::REQ_MAP, tpe_pkg::REQ_UNMAP,
                                             tpe_pkg::REQ_TRANSLATE}) begin
                        ram_re     = 1'b1;
                        ram_raddr  = {{tpe_pkg::FRAME_W{1'b0}}, req.virt_addr[38:30]};
                        state_next = S_RD1;
                    end else begin
                        res_next   = '{status: tpe_pkg::ST_OK, translated_addr: '0,
                                       leaf_descriptor: '0};
                        state_next = S_DONE;
                    end
                end
            end

            S_RD1, S_RD2: begin
                if (d_valid) begin
                    if (!d_table) begin
                        res_next   = '{status: tpe_pkg::ST_BLOCK_LEAF, translated_addr: '0,
                                       leaf_descriptor: '0};
                        state_next = S_DONE;
                    end else if (d_out_of_pool) begin
                        res_next   = '{status: tpe_pkg::ST_NOT_MAPPED, translated_addr: '0,
                                       leaf_descriptor: '0};
                        state_next = S_DONE;
                    end else begin
                        descend = 1'b1;
                    end
                end else if (op_reg == tpe_pkg::REQ_MAP) begin
                    if (pool_empty) begin
                        res_next   = '{status: tpe_pkg::ST_EXHAUSTED, translated_addr: '0,
                                       leaf_descriptor: '0};
                        state_next = S_DONE;
                    end else begin
                        // New frame is still zero from the reset sweep.
                        ram_we    = 1'b1;
                        ram_waddr = {parent, cur_idx};
                        ram_wdata = tpe_pkg::table_desc(alloc_frame);
                        nff_next  = nff_reg + tpe_pkg::NFF_W'(1);
                        child     = alloc_frame;
                        descend   = 1'b1;
                    end
                end else begin
                    res_next   = '{status: tpe_pkg::ST_NOT_MAPPED, translated_addr: '0,
                                   leaf_descriptor: '0};
                    state_next = S_DONE;
                end

                if (descend) begin
                    frame_next = child;
                    if (state_reg == S_RD1) begin
                        ram_re     = 1'b1;
                        ram_raddr  = {child, i2};
                        state_next = S_RD2;
                    end else if (op_reg == tpe_pkg::REQ_MAP) begin
                        state_next = S_LEAF;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = {child, i3};
                        state_next = S_RD3;
                    end
                end
            end

            S_LEAF: begin
                if (flags_reg[0]) begin
                    ram_we     = 1'b1;
                    ram_waddr  = {frame_reg, i3};
                    ram_wdata  = {{tpe_pkg::HI_PAD_W{1'b0}}, pa_reg,
                                  tpe_pkg::page_attrs(flags_reg)};
                    res_next   = '{status: tpe_pkg::ST_OK, translated_addr: '0,
                                   leaf_descriptor: ram_wdata};
                end else begin
                    res_next   = '{status: tpe_pkg::ST_NOT_PRESENT, translated_addr: '0,
                                   leaf_descriptor: '0};
                end
                state_next = S_DONE;
            end

            S_RD3: begin
                if (op_reg == tpe_pkg::REQ_UNMAP) begin
                    ram_we    = 1'b1;
                    ram_waddr = {frame_reg, i3};
                    res_next  = '{status: d_valid ? tpe_pkg::ST_OK : tpe_pkg::ST_NOT_MAPPED,
                                  translated_addr: '0, leaf_descriptor: '0};
                end else if (d_valid) begin
                    res_next  = '{status: tpe_pkg::ST_OK,
                                  translated_addr: {ram_rdata[47:12], va_reg[11:0]},
                                  leaf_descriptor: ram_rdata};
                end else begin
                    res_next  = '{status: tpe_pkg::ST_NOT_MAPPED, translated_addr: '0,
                                  leaf_descriptor: ram_rdata};
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, allocator and captured request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            nff_reg     <= tpe_pkg::NFF_W'(1);
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            nff_reg     <= nff_next;
        end
        op_reg    <= op_next;
        va_reg    <= va_next;
        pa_reg    <= pa_next;
        flags_reg <= flags_next;
        frame_reg <= frame_next;
        res_reg   <= res_next;
    end

    // The allocator never runs past the pool.
    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nff_reg <= tpe_pkg::NFF_W'(tpe_pkg::TABLE_FRAMES))
        else $error("allocator ran past the frame pool");

    // The allocator hands out at most one frame per cycle.
    a_alloc_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (nff_reg == $past(nff_reg)
                         || nff_reg == $past(nff_reg) + tpe_pkg::NFF_W'(1)))
        else $error("allocator moved by more than one frame");

    // Walk writes only land in frames already handed out.
    a_write_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg != S_CLEAR) |->
        (tpe_pkg::NFF_W'(ram_waddr[tpe_pkg::ADDR_W-1 -: tpe_pkg::FRAME_W]) < nff_reg))
        else $error("table write outside allocated frames");

    // No item is taken while the reset sweep runs.
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> (!req_ready && !res_valid))
        else $error("request handshake during reset sweep");

endmodule

`default_nettype wire

// ----- src/three_level_page_table_engine.sv -----
`default_nettype none

// Channel   Handshake         Fields                                                 Dir
// -------   ---------------   ----------------------------------------------------   ---
// request   s_valid/s_ready   s_req_type, s_virt_addr, s_phys_addr, s_access_flags   in
// result    m_valid/m_ready   m_status, m_translated_addr, m_leaf_descriptor         out
//
// A walk accepts the request with the L1 read, works through each table level
// in turn on the single table memory, then hands off to the output register.
// A walk may stop at L1 or at L2, and an unknown request type goes straight
// to the hand-off. After reset the table memory is swept to zero, all
// TABLE_FRAMES * 512 entries (8192 here), before s_ready rises.
// A stalled result sits in the output register while the next item walks;
// that item then waits for the register to drain before finishing.

module three_level_page_table_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_req_type,
    input  wire logic [tpe_pkg::VA_W-1:0]      s_virt_addr,
    input  wire logic [tpe_pkg::PA_W-1:0]      s_phys_addr,
    input  wire logic [2:0]                    s_access_flags,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [2:0]                         m_status,
    output logic [tpe_pkg::PA_W-1:0]           m_translated_addr,
    output logic [tpe_pkg::DESC_W-1:0]         m_leaf_descriptor
);

    tpe_pkg::req_t               req;
    tpe_pkg::res_t               res;
    logic                        res_valid, res_ready;
    logic                        ram_we, ram_re;
    logic [tpe_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [tpe_pkg::DESC_W-1:0]  ram_wdata, ram_rdata;
    logic                        m_valid_reg, m_valid_next;
    tpe_pkg::res_t               out_reg, out_next;

    assign req = '{req_type: s_req_type, virt_addr: s_virt_addr,
                   phys_addr: s_phys_addr, access_flags: s_access_flags};

    tpe_walk u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tpe_ram #(
        .DEPTH  (tpe_pkg::DEPTH),
        .ADDR_W (tpe_pkg::ADDR_W),
        .DATA_W (tpe_pkg::DESC_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Output register: loads when empty or draining this cycle.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = out_reg.status;
    assign m_translated_addr = out_reg.translated_addr;
    assign m_leaf_descriptor = out_reg.leaf_descriptor;

endmodule

`default_nettype wire
